// File: rtl/core/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// shared types and constants of the soft cluster membership block
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int ACC_W = 40;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam int SQ_IN_W = 20;
    localparam int Q15_W = 16;
    localparam logic [Q15_W-1:0] Q15_ONE = 16'h8000;
    localparam int FRAC_STEPS = 15;
    localparam int CLUSTER_W = 4;
    localparam int DIM_W = 4;
    localparam int ALPHA_W = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd256;
    localparam int PADDR_W = 3;
    localparam logic REG_ALPHA = 1'b0;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } op_t;

endpackage

// File: rtl/core/scm_div.sv
// ----------------------------------------------------------------------------
// scm_div
// restoring fraction divider, floor(2^15 * num / den) saturated to 1.0, zero when den is zero
// ----------------------------------------------------------------------------
module scm_div import scm_pkg::*;
#(
    parameter int W = 49
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    output logic             done,
    output logic [Q15_W-1:0] quot
);

    typedef enum logic [1:0]
    {
        D_IDLE,
        D_RUN,
        D_DONE
    } dstate_t;

    dstate_t          state_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     den_reg;
    logic [Q15_W-1:0] q_reg;
    logic [3:0]       cnt_reg;
    logic [W:0]       rem2;
    logic             ge;

    assign rem2 = {rem_reg, 1'b0};
    assign ge   = rem2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        den_reg <= den;
                        rem_reg <= num;
                        cnt_reg <= '0;
                        if (den == '0)
                        begin
                            q_reg     <= '0;
                            state_reg <= D_DONE;
                        end
                        else if (num >= den)
                        begin
                            q_reg     <= Q15_ONE;
                            state_reg <= D_DONE;
                        end
                        else
                        begin
                            q_reg     <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? W'(rem2 - {1'b0, den_reg}) : W'(rem2);
                    q_reg   <= {q_reg[Q15_W-2:0], ge};
                    cnt_reg <= 4'(cnt_reg + 1'b1);
                    if (cnt_reg == 4'(FRAC_STEPS - 1))
                    begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = state_reg == D_DONE;
    assign quot = q_reg;

endmodule

// File: rtl/core/soft_cluster_membership.sv
// ----------------------------------------------------------------------------
// soft_cluster_membership
// regularized soft k-means membership unit with a shared multiply-accumulate
// ----------------------------------------------------------------------------
// a word is taken on start while busy is low; loads (operation 0) write one
// centroid coordinate and keep busy low
// a point word (operation 1) with a valid dimension steps each cluster through
// S_ARD, S_AMUL and S_AADD in one shared square-accumulate unit, busy high
// a point word with last_coord then sums the distances (S_SRD, S_SADD per
// cluster), forms the minimum and denominator (S_NMIN, S_DEN), and per cluster
// forms the numerator (S_MRD, S_MNUM) and runs the shared divider; one
// result word per cluster comes out with result_valid high for a single cycle
// the receiver cannot stall: each result word is taken in its cycle
// alpha is written over the apb port while idle, a rule on the user that the
// block does not enforce; reset sets alpha to 1.0 and clears all distance
// accumulators at once; centroids hold garbage until written
// ----------------------------------------------------------------------------
module soft_cluster_membership import scm_pkg::*;
#(
    parameter int NUM_CLUSTERS = 16,
    parameter int NUM_DIMS = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [CLUSTER_W-1:0]  cluster,
    input  logic [DIM_W-1:0]      dim_index,
    input  logic [COORD_BITS-1:0] coord_value,
    input  logic                  last_coord,
    output logic                  result_valid,
    output logic [CLUSTER_W-1:0]  cluster_index,
    output logic [Q15_W-1:0]      membership,
    output logic                  last
);

    localparam int CW = $clog2(NUM_CLUSTERS);
    localparam int AW = $clog2(NUM_CLUSTERS * NUM_DIMS);
    localparam int SW = ACC_W + CW;
    localparam int NW = SW + 3;
    localparam int DW = SW + CW + 1;
    localparam int XW = COORD_BITS + 1;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_ARD,
        S_AMUL,
        S_AADD,
        S_SRD,
        S_SADD,
        S_NMIN,
        S_DEN,
        S_MRD,
        S_MNUM,
        S_MDIV
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           j_reg;
    logic [DIM_W-1:0]        dim_reg;
    logic [COORD_BITS-1:0]   x_reg;
    logic                    last_pend_reg;
    logic [ACC_W-1:0]        sq_reg;
    logic [SW-1:0]           sum_reg;
    logic [ACC_W-1:0]        dmax_reg;
    logic signed [NW-1:0]    nmin_reg;
    logic [DW-1:0]           den_reg;
    logic [DW-1:0]           num_reg;
    logic                    div_start_reg;
    logic [ALPHA_W-1:0]      alpha_reg;
    logic                    strobe_reg;
    logic [CLUSTER_W-1:0]    idx_reg;
    logic [Q15_W-1:0]        mem_reg;
    logic                    out_last_reg;

    logic [COORD_BITS-1:0]   cent_mem [NUM_CLUSTERS*NUM_DIMS];
    logic [COORD_BITS-1:0]   cent_q;
    logic [ACC_W-1:0]        acc_mem [NUM_CLUSTERS];
    logic [ACC_W-1:0]        acc_q;
    logic [NUM_CLUSTERS-1:0] acc_vld_reg;
    logic                    vld_q;

    logic                    accept;
    logic                    load_ok;
    logic                    dim_ok;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic [ACC_W-1:0]        acc_eff;
    logic signed [XW-1:0]    diff;
    logic [63:0]             ad64;
    logic [ACC_W-1:0]        sq_val;
    logic [ACC_W:0]          acc_sum;
    logic [ACC_W-1:0]        acc_new;
    logic signed [NW-1:0]    two_a;
    logic signed [NW-1:0]    n_max;
    logic signed [NW-1:0]    n_cur;
    logic signed [NW-1:0]    t_den;
    logic                    j_end;
    logic                    div_done;
    logic [Q15_W-1:0]        div_quot;

    assign accept  = start && !busy;
    assign load_ok = (int'(cluster) < NUM_CLUSTERS) && (int'(dim_index) < NUM_DIMS);
    assign dim_ok  = int'(dim_index) < NUM_DIMS;
    assign wr_addr = AW'(int'(cluster) * NUM_DIMS + int'(dim_index));
    assign rd_addr = AW'(int'(j_reg) * NUM_DIMS + int'(dim_reg));
    assign j_end   = j_reg == CW'(NUM_CLUSTERS - 1);

    assign acc_eff = vld_q ? acc_q : '0;
    assign diff    = $signed({x_reg[COORD_BITS-1], x_reg})
                   - $signed({cent_q[COORD_BITS-1], cent_q});
    assign ad64    = diff[XW-1] ? 64'(-diff) : 64'(diff);
    assign sq_val  = (ad64 >= (64'd1 << SQ_IN_W)) ? ACC_MAX
                   : ACC_W'(ad64[SQ_IN_W-1:0] * ad64[SQ_IN_W-1:0]);
    assign acc_sum = {1'b0, acc_eff} + {1'b0, sq_reg};
    assign acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    assign two_a = $signed(NW'({alpha_reg, 9'b0}));
    assign n_max = two_a + $signed(NW'(sum_reg))
                 - $signed(NW'(dmax_reg) * NW'(NUM_CLUSTERS));
    assign n_cur = two_a + $signed(NW'(sum_reg))
                 - $signed(NW'(acc_eff) * NW'(NUM_CLUSTERS)) - nmin_reg;
    assign t_den = two_a - nmin_reg;

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD && load_ok)
        begin
            cent_mem[wr_addr] <= coord_value;
        end
        cent_q <= cent_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_AADD)
        begin
            acc_mem[j_reg] <= acc_new;
        end
        acc_q <= acc_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
            vld_q       <= 1'b0;
        end
        else
        begin
            vld_q <= acc_vld_reg[j_reg];
            if (state_reg == S_AADD)
            begin
                acc_vld_reg[j_reg] <= 1'b1;
            end
            else if (state_reg == S_MDIV && div_done)
            begin
                acc_vld_reg[j_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_ALPHA)
        begin
            alpha_reg <= pwdata[ALPHA_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALPHA) ? 32'(alpha_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            last_pend_reg <= 1'b0;
            div_start_reg <= 1'b0;
            strobe_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg    <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && operation == OP_POINT)
                    begin
                        j_reg         <= '0;
                        dim_reg       <= dim_index;
                        x_reg         <= coord_value;
                        last_pend_reg <= last_coord;
                        sum_reg       <= '0;
                        dmax_reg      <= '0;
                        if (dim_ok)
                        begin
                            state_reg <= S_ARD;
                        end
                        else if (last_coord)
                        begin
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_ARD:
                begin
                    state_reg <= S_AMUL;
                end
                S_AMUL:
                begin
                    sq_reg    <= sq_val;
                    state_reg <= S_AADD;
                end
                S_AADD:
                begin
                    if (j_end)
                    begin
                        j_reg     <= '0;
                        state_reg <= last_pend_reg ? S_SRD : S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= CW'(j_reg + 1'b1);
                        state_reg <= S_ARD;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SADD;
                end
                S_SADD:
                begin
                    sum_reg <= SW'(sum_reg + SW'(acc_eff));
                    if (acc_eff > dmax_reg)
                    begin
                        dmax_reg <= acc_eff;
                    end
                    if (j_end)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_NMIN;
                    end
                    else
                    begin
                        j_reg     <= CW'(j_reg + 1'b1);
                        state_reg <= S_SRD;
                    end
                end
                S_NMIN:
                begin
                    nmin_reg  <= (n_max < 0) ? n_max : '0;
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    den_reg   <= DW'($unsigned(t_den)) * DW'(NUM_CLUSTERS);
                    state_reg <= S_MRD;
                end
                S_MRD:
                begin
                    state_reg <= S_MNUM;
                end
                S_MNUM:
                begin
                    num_reg       <= DW'($unsigned(n_cur));
                    div_start_reg <= 1'b1;
                    state_reg     <= S_MDIV;
                end
                S_MDIV:
                begin
                    if (div_done)
                    begin
                        strobe_reg   <= 1'b1;
                        idx_reg      <= CLUSTER_W'(j_reg);
                        mem_reg      <= div_quot;
                        out_last_reg <= j_end;
                        if (j_end)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= CW'(j_reg + 1'b1);
                            state_reg <= S_MRD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    scm_div #(
        .W(DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign busy          = state_reg != S_IDLE;
    assign result_valid  = strobe_reg;
    assign cluster_index = idx_reg;
    assign membership    = mem_reg;
    assign last          = out_last_reg;

`ifndef SYNTH
    a_mem_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> membership <= Q15_ONE)
        else $error("membership above one");
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result after last");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_LOAD |=> !busy)
        else $error("load made block busy");
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("idle mid result sequence");
`endif

endmodule

// File: bench/soft_cluster_membership_test.sv
// ----------------------------------------------------------------------------
// soft_cluster_membership_test
// self-checking bench: centroid loads and point words go in over start/busy,
// alpha is set over apb while idle, and every membership word is compared
// with a local prediction of the accumulate, minimum and divide steps
// ----------------------------------------------------------------------------
module soft_cluster_membership_test;
    import scm_pkg::*;

    localparam int K = 16;
    localparam int DIMS = 16;
    localparam int LOADED_DIMS = 4;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [PADDR_W-1:0] ADDR_ALPHA = {REG_ALPHA, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'b100;

    typedef struct
    {
        logic [CLUSTER_W-1:0] idx;
        logic [Q15_W-1:0]     mem;
        logic                 lst;
    } membership_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic                 operation;
    logic [CLUSTER_W-1:0] cluster;
    logic [DIM_W-1:0]     dim_index;
    logic [15:0]          coord_value;
    logic                 last_coord;
    logic                 result_valid;
    logic [CLUSTER_W-1:0] cluster_index;
    logic [Q15_W-1:0]     membership;
    logic                 last;

    membership_word_t pending_words[$];
    logic [15:0]      centroid_mem[K*DIMS];
    logic [39:0]      dist_acc[K];
    logic [15:0]      alpha_now;
    int               error_count;
    int               words_checked;
    int               words_sent;
    int               cycle_count;
    int               burst_left;
    bit               steady_send;

    soft_cluster_membership dut
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .operation(operation), .cluster(cluster), .dim_index(dim_index),
        .coord_value(coord_value), .last_coord(last_coord),
        .result_valid(result_valid), .cluster_index(cluster_index),
        .membership(membership), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("error: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic [15:0] ratio_q15(input longint num, input longint den);
        longint q;
        longint r;
        if (num >= den)
            return Q15_ONE;
        q = 0;
        r = num;
        for (int i = 0; i < FRAC_STEPS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q > 32768) ? Q15_ONE : q[15:0];
    endfunction

    // predicted effect of one accepted word
    function automatic void predict_word(input logic op, input logic [3:0] cl,
                                         input logic [3:0] dim, input logic [15:0] val,
                                         input logic lc);
        longint x;
        longint d;
        longint acc;
        longint s;
        longint two_a;
        longint nmin;
        longint den;
        longint n[K];
        membership_word_t w;
        if (op == OP_LOAD)
        begin
            centroid_mem[{cl, dim}] = val;
            return;
        end
        x = longint'($signed(val));
        for (int j = 0; j < K; j++)
        begin
            d = x - longint'($signed(centroid_mem[j*DIMS + dim]));
            if (d < 0)
                d = -d;
            acc = longint'(dist_acc[j]) + d * d;
            dist_acc[j] = (acc > longint'(ACC_MAX)) ? ACC_MAX : acc[39:0];
        end
        if (!lc)
            return;
        s = 0;
        for (int j = 0; j < K; j++)
            s += longint'(dist_acc[j]);
        two_a = longint'(alpha_now) * 512;
        nmin = 0;
        for (int j = 0; j < K; j++)
        begin
            n[j] = two_a + s - K * longint'(dist_acc[j]);
            if (n[j] < nmin)
                nmin = n[j];
        end
        den = K * two_a - K * nmin;
        for (int j = 0; j < K; j++)
        begin
            w.idx = 4'(j);
            w.mem = (den == 0) ? 16'd0 : ratio_q15(n[j] - nmin, den);
            w.lst = (j == K - 1);
            pending_words = {pending_words, w};
            dist_acc[j] = '0;
        end
    endfunction

    always @(posedge clk)
    begin
        membership_word_t w;
        if (rst_n && result_valid)
        begin
            if (pending_words.size() == 0)
                report("unexpected word, cluster", cluster_index, -1);
            else
            begin
                w = pending_words.pop_front();
                words_checked++;
                if (cluster_index !== w.idx)
                    report("cluster_index", cluster_index, w.idx);
                if (membership !== w.mem)
                    report("membership", membership, w.mem);
                if (last !== w.lst)
                    report("last", last, w.lst);
            end
        end
    end

    task automatic send_word(input logic op, input logic [3:0] cl, input logic [3:0] dim,
                             input logic [15:0] val, input logic lc);
        start <= 1'b1;
        operation <= op;
        cluster <= cl;
        dim_index <= dim;
        coord_value <= val;
        last_coord <= lc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(op, cl, dim, val, lc);
        words_sent++;
        if (steady_send || burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic settle;
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == REG_ALPHA)
            alpha_now = data[15:0];
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord;
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic load_all_centroids;
        for (int c = 0; c < K; c++)
            for (int m = 0; m < LOADED_DIMS; m++)
                send_word(OP_LOAD, 4'(c), 4'(m), pick_coord(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_point(input int len);
        for (int i = 0; i < len; i++)
            send_word(OP_POINT, 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, LOADED_DIMS - 1)),
                      pick_coord(), i == len - 1);
    endtask

    task automatic test_default_alpha;
        load_all_centroids();
        send_word(OP_POINT, 4'd15, 4'd0, 16'h7fff, 1'b0);
        send_word(OP_POINT, 4'd0, 4'd3, 16'h8000, 1'b1);
        send_word(OP_POINT, 4'd0, 4'd2, 16'h0000, 1'b1);
    endtask

    task automatic test_alpha_extremes;
        write_reg(ADDR_ALPHA, 32'd65535);
        send_word(OP_POINT, 4'd0, 4'd1, 16'hffff, 1'b1);
        send_point(3);
        write_reg(ADDR_ALPHA, 32'd1);
        send_word(OP_POINT, 4'd0, 4'd2, 16'h7fff, 1'b0);
        send_word(OP_POINT, 4'd0, 4'd3, 16'h8000, 1'b1);
    endtask

    task automatic test_equal_centroids;
        for (int c = 0; c < K; c++)
            send_word(OP_LOAD, 4'(c), 4'd0, 16'h1234, 1'b1);
        send_word(OP_POINT, 4'd0, 4'd0, 16'h1234, 1'b1);
        write_reg(ADDR_ALPHA, 32'd0);
        send_word(OP_POINT, 4'd0, 4'd0, 16'h1234, 1'b1);
        send_point(2);
        write_reg(ADDR_UNMAPPED, 32'd777);
        send_word(OP_POINT, 4'd0, 4'd0, 16'h1234, 1'b1);
    endtask

    task automatic test_random;
        int sent;
        int len;
        sent = 0;
        while (sent < 160)
        begin
            if (sent % 60 == 0)
                write_reg(ADDR_ALPHA, $urandom_range(1, 65535));
            steady_send = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:
                begin
                    send_word(OP_LOAD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              pick_coord(), 1'($urandom_range(0, 1)));
                    len = 1;
                end
                1:
                begin
                    len = $urandom_range(17, 30);
                    send_point(len);
                end
                default:
                begin
                    len = $urandom_range(1, 16);
                    send_point(len);
                end
            endcase
            sent += len;
        end
        steady_send = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        operation = OP_LOAD;
        cluster = '0;
        dim_index = '0;
        coord_value = '0;
        last_coord = 1'b0;
        error_count = 0;
        words_checked = 0;
        words_sent = 0;
        cycle_count = 0;
        burst_left = 0;
        steady_send = 1'b0;
        alpha_now = ALPHA_RESET;
        for (int j = 0; j < K; j++)
            dist_acc[j] = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_alpha();
        test_alpha_extremes();
        test_equal_centroids();
        test_random();
        settle();
        repeat (50)
            @(posedge clk);

        $display("sent %0d words, checked %0d membership words", words_sent, words_checked);
        $display("alpha swept 0 to 65535, equal centroids, zero denominator, unmapped write");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
